>>> src/pxenc_pkg.sv
// ============================================================================
// pxenc_pkg
// Shared types, byte codes and helper functions for the pixel to terminal
// character encoder.
// ============================================================================
package pxenc_pkg;

    // default depth of the command queue between front and back
    localparam int unsigned PE_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // digit positions inside a decimal field
    localparam logic [2:0] DIG_HUND = 3'd0;
    localparam logic [2:0] DIG_TENS = 3'd1;
    localparam logic [2:0] DIG_ONES = 3'd2;

    // last index of the fixed escape prefixes
    localparam logic [2:0] RST_LAST = 3'd3;
    localparam logic [2:0] HDR_LAST = 3'd6;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [2:0] start;   // first digit emitted, drops leading zeros
    } dec_t;

    typedef struct packed {
        dec_t       red;
        dec_t       green;
        dec_t       blue;
        logic [7:0] glyph;
        logic       row_end;
        logic       color;
    } pix_cmd_t;

    typedef enum logic [3:0] {
        PH_RST,
        PH_HDR,
        PH_RED,
        PH_SEP1,
        PH_GREEN,
        PH_SEP2,
        PH_BLUE,
        PH_MARK,
        PH_GLYPH,
        PH_NL
    } phase_t;

    function automatic dec_t to_decimal(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        dec_t        d;
        if (v >= 8'd200) begin
            h = 2'd2;
        end else if (v >= 8'd100) begin
            h = 2'd1;
        end else begin
            h = 2'd0;
        end
        rem  = 7'(v - 8'(h) * 8'd100);
        // x * 205 >> 11 equals x / 10 for every x below 1029
        prod = 15'(rem) * 15'd205;
        t    = 4'(prod >> 11);
        d.hund = {2'b00, h};
        d.tens = t;
        d.ones = 4'(rem - 7'(t) * 7'd10);
        if (v >= 8'd100) begin
            d.start = DIG_HUND;
        end else if (v >= 8'd10) begin
            d.start = DIG_TENS;
        end else begin
            d.start = DIG_ONES;
        end
        return d;
    endfunction

    function automatic logic [7:0] digit_char(input dec_t d, input logic [2:0] idx);
        logic [3:0] dg;
        case (idx)
            DIG_HUND: dg = d.hund;
            DIG_TENS: dg = d.tens;
            default:  dg = d.ones;
        endcase
        return CH_ZERO | {4'h0, dg};
    endfunction

    function automatic logic [7:0] ramp_glyph(input logic [7:0] lum);
        logic [7:0] c;
        if (lum < 8'd29) begin
            c = 8'h20;          // space
        end else if (lum < 8'd58) begin
            c = 8'h2E;          // '.'
        end else if (lum < 8'd87) begin
            c = 8'h2C;          // ','
        end else if (lum < 8'd116) begin
            c = 8'h2D;          // '-'
        end else if (lum < 8'd145) begin
            c = 8'h7E;          // '~'
        end else if (lum < 8'd174) begin
            c = 8'h2A;          // '*'
        end else if (lum < 8'd203) begin
            c = 8'h31;          // '1'
        end else if (lum < 8'd232) begin
            c = 8'h39;          // '9'
        end else if (lum < 8'd255) begin
            c = 8'h57;          // 'W'
        end else begin
            c = 8'h40;          // '@'
        end
        return c;
    endfunction

endpackage

>>> src/pxenc_front.sv
// ============================================================================
// pxenc_front
// Accepts pixels, converts the colour bytes to decimal digits, picks the
// ramp glyph and holds the colour enable register.
// ============================================================================
module pxenc_front
    import pxenc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_luminance,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic       s_row_end,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output pix_cmd_t   cmd_data
);

    logic     color_enable_reg;
    logic     valid_reg;
    pix_cmd_t cmd_reg;
    pix_cmd_t cmd_next;

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        cmd_next.red     = to_decimal(s_red);
        cmd_next.green   = to_decimal(s_green);
        cmd_next.blue    = to_decimal(s_blue);
        cmd_next.glyph   = ramp_glyph(s_luminance);
        cmd_next.row_end = s_row_end;
        cmd_next.color   = color_enable_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            color_enable_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> src/pxenc_queue.sv
// ============================================================================
// pxenc_queue
// Short first-in first-out queue of pixel commands between front and back.
// ============================================================================
module pxenc_queue
    import pxenc_pkg::*;
#(
    parameter int unsigned DEPTH = PE_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  pix_cmd_t wr_data,
    output logic     rd_valid,
    input  logic     rd_pop,
    output pix_cmd_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pix_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/pxenc_back.sv
// ============================================================================
// pxenc_back
// Serialises the command at the head of the queue into terminal bytes, one
// per cycle unless m_ready stalls it, through a single output register.
// ============================================================================
module pxenc_back
    import pxenc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    output logic       cmd_pop,
    input  pix_cmd_t   cmd_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [7:0] byte_cur;
    logic       last_cur;
    logic       load;

    assign load    = cmd_valid && (!out_valid_reg || m_ready);
    assign cmd_pop = load && last_cur;

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = out_last_reg;

    // next step of the run
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg + 1'b1;
        case (phase_reg)
            PH_RST: begin
                if (idx_reg == RST_LAST) begin
                    phase_next = cmd_data.color ? PH_HDR : PH_GLYPH;
                    idx_next   = '0;
                end
            end
            PH_HDR: begin
                if (idx_reg == HDR_LAST) begin
                    phase_next = PH_RED;
                    idx_next   = cmd_data.red.start;
                end
            end
            PH_RED: begin
                if (idx_reg == DIG_ONES) begin
                    phase_next = PH_SEP1;
                end
            end
            PH_SEP1: begin
                phase_next = PH_GREEN;
                idx_next   = cmd_data.green.start;
            end
            PH_GREEN: begin
                if (idx_reg == DIG_ONES) begin
                    phase_next = PH_SEP2;
                end
            end
            PH_SEP2: begin
                phase_next = PH_BLUE;
                idx_next   = cmd_data.blue.start;
            end
            PH_BLUE: begin
                if (idx_reg == DIG_ONES) begin
                    phase_next = PH_MARK;
                end
            end
            PH_MARK: begin
                phase_next = PH_GLYPH;
            end
            PH_GLYPH: begin
                phase_next = cmd_data.row_end ? PH_NL : PH_RST;
                idx_next   = '0;
            end
            PH_NL: begin
                phase_next = PH_RST;
                idx_next   = '0;
            end
            default: begin
                phase_next = PH_RST;
                idx_next   = '0;
            end
        endcase
    end

    // byte for the current step
    always_comb begin
        byte_cur = CH_SEMI;
        last_cur = 1'b0;
        case (phase_reg)
            PH_RST: begin
                case (idx_reg)
                    3'd0:    byte_cur = CH_ESC;
                    3'd1:    byte_cur = CH_LBRACK;
                    3'd2:    byte_cur = CH_ZERO;
                    default: byte_cur = CH_M;
                endcase
            end
            PH_HDR: begin
                case (idx_reg)
                    3'd0:    byte_cur = CH_ESC;
                    3'd1:    byte_cur = CH_LBRACK;
                    3'd2:    byte_cur = CH_THREE;
                    3'd3:    byte_cur = CH_EIGHT;
                    3'd5:    byte_cur = CH_TWO;
                    default: byte_cur = CH_SEMI;
                endcase
            end
            PH_RED:   byte_cur = digit_char(cmd_data.red, idx_reg);
            PH_GREEN: byte_cur = digit_char(cmd_data.green, idx_reg);
            PH_BLUE:  byte_cur = digit_char(cmd_data.blue, idx_reg);
            PH_SEP1:  byte_cur = CH_SEMI;
            PH_SEP2:  byte_cur = CH_SEMI;
            PH_MARK:  byte_cur = CH_M;
            PH_GLYPH: begin
                byte_cur = cmd_data.glyph;
                last_cur = !cmd_data.row_end;
            end
            PH_NL: begin
                byte_cur = CH_NL;
                last_cur = 1'b1;
            end
            default: begin
                byte_cur = CH_SEMI;
                last_cur = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RST;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= byte_cur;
            out_last_reg <= last_cur;
        end
    end

endmodule

>>> src/pixel_to_ansi_char_encoder.sv
// ============================================================================
// pixel_to_ansi_char_encoder
// Turns pixels into terminal byte runs: reset escape, optional truecolour
// foreground escape, ramp glyph and an optional newline.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    luminance, red, green, blue, row_end
//   m_       out        m_valid/m_ready    out_byte, last
//   cfg_     in         cfg_wr_en          cfg_wr_data (colour enable)
//
// One byte leaves per cycle unless the output stalls, so a pixel yields
// 5 to 25 bytes: 5 without colour, 18 to 24 with colour, plus one for a
// newline. The first byte passes the front, queue and output registers.
// The front stage and command queue keep taking pixels while the back end
// serialises, so input and output stall independently.
// Reset is synchronous; it empties the queue and sets colour enable to 1.
// ============================================================================
module pixel_to_ansi_char_encoder
    import pxenc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = PE_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_luminance,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic       s_row_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic     front_valid;
    logic     front_ready;
    pix_cmd_t front_cmd;
    logic     head_valid;
    logic     head_pop;
    pix_cmd_t head_cmd;

    pxenc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_luminance (s_luminance),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_row_end   (s_row_end),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd_data    (front_cmd)
    );

    pxenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_data  (head_cmd)
    );

    pxenc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (head_valid),
        .cmd_pop    (head_pop),
        .cmd_data   (head_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

>>> src/pxenc_checker.sv
// ============================================================================
// pxenc_checker
// Port-level checks on the encoder output stream, bound to the top level.
// ============================================================================
module pxenc_checker
    import pxenc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    logic at_start_reg;

    // track whether the next output transfer opens a new run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            at_start_reg <= m_last;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("output changed while stalled");

    a_run_opens_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && at_start_reg |-> m_out_byte == CH_ESC)
        else $error("run does not open with escape");

    a_last_not_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_out_byte != CH_ESC && m_out_byte != CH_SEMI)
        else $error("run closed on an escape byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind pixel_to_ansi_char_encoder pxenc_checker u_pxenc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_last     (m_last)
);

>>> sim/testbench.sv
// ============================================================================
// Pixel encoder testbench
// Feeds pixels through the valid/ready input and checks every byte of the
// terminal stream. Each expected run is worked out from the pixel and the
// colour setting in force when the pixel transfers. The colour setting is
// changed only after the stream has drained. Both sides stall at random.
// ============================================================================
module testbench;

    localparam logic [7:0] ESC_CODE      = 8'h1B;
    localparam logic [7:0] NEWLINE       = 8'h0A;
    localparam logic [31:0] RESET_SEQ    = {ESC_CODE, "[0m"};
    localparam logic [55:0] FG_SEQ       = {ESC_CODE, "[38;2;"};
    // luminance bounds, lowest first in the top byte; glyphs likewise
    localparam logic [71:0] RAMP_BOUNDS  = {8'd29, 8'd58, 8'd87, 8'd116, 8'd145,
                                            8'd174, 8'd203, 8'd232, 8'd255};
    localparam logic [79:0] RAMP_CHARS   = " .,-~*19W@";
    // decimal width edges for the colour components
    localparam logic [63:0] DEC_EDGES    = {8'd0, 8'd9, 8'd10, 8'd99, 8'd100,
                                            8'd199, 8'd200, 8'd255};
    localparam int RUN_BYTES_MAX = 25;
    localparam int MAX_GAP       = 13;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 50;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum logic [1:0] {
        JOB_PIXEL,
        JOB_SET_COLOUR,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t  kind;
        logic [7:0] lum;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       colour;
        int         gap;
    } job_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } term_byte_t;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_luminance = 8'd0;
    logic [7:0] s_red       = 8'd0;
    logic [7:0] s_green     = 8'd0;
    logic [7:0] s_blue      = 8'd0;
    logic       s_row_end   = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;

    job_t       job_q[$];
    term_byte_t stream_q[$];
    job_t       cur_pixel;
    logic       colour_on;
    int         wait_left;
    int         stall_left;
    int         rx_mode;
    int         rx_count;
    int         mismatches = 0;

    pixel_to_ansi_char_encoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_luminance (s_luminance),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_row_end   (s_row_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Append the byte run that one pixel should produce to the stream store.
    function automatic void predict_pixel_run(input job_t px, input logic colour);
        logic [7:0] run [RUN_BYTES_MAX];
        logic [7:0] comp;
        int         n;
        int         k;
        int         glyph_idx;
        n = 0;
        for (k = 0; k < 4; k++) begin
            run[n] = RESET_SEQ[(3 - k) * 8 +: 8];
            n++;
        end
        if (colour) begin
            for (k = 0; k < 7; k++) begin
                run[n] = FG_SEQ[(6 - k) * 8 +: 8];
                n++;
            end
            for (k = 0; k < 3; k++) begin
                comp = (k == 0) ? px.red : (k == 1) ? px.green : px.blue;
                // drop leading zeros
                if (comp >= 8'd100) begin
                    run[n] = "0" + comp / 8'd100;
                    n++;
                end
                if (comp >= 8'd10) begin
                    run[n] = "0" + (comp / 8'd10) % 8'd10;
                    n++;
                end
                run[n] = "0" + comp % 8'd10;
                n++;
                run[n] = (k == 2) ? "m" : ";";
                n++;
            end
        end
        glyph_idx = 9;
        for (k = 8; k >= 0; k--) begin
            if (px.lum < RAMP_BOUNDS[(8 - k) * 8 +: 8]) begin
                glyph_idx = k;
            end
        end
        run[n] = RAMP_CHARS[(9 - glyph_idx) * 8 +: 8];
        n++;
        if (px.row_end) begin
            run[n] = NEWLINE;
            n++;
        end
        for (k = 0; k < n; k++) begin
            stream_q.push_back('{code: run[k], last: (k == n - 1)});
        end
    endfunction

    function automatic void add_pixel(input logic [7:0] lum, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue,
                                      input logic row_end, input int gap);
        job_t j;
        j.kind    = JOB_PIXEL;
        j.lum     = lum;
        j.red     = red;
        j.green   = green;
        j.blue    = blue;
        j.row_end = row_end;
        j.colour  = 1'b0;
        j.gap     = gap;
        job_q.push_back(j);
    endfunction

    function automatic void add_colour(input logic value);
        job_t j;
        j.kind    = JOB_SET_COLOUR;
        j.lum     = 8'd0;
        j.red     = 8'd0;
        j.green   = 8'd0;
        j.blue    = 8'd0;
        j.row_end = 1'b0;
        j.colour  = value;
        j.gap     = 0;
        job_q.push_back(j);
    endfunction

    function automatic logic [7:0] random_component();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 255));
            default: return DEC_EDGES[$urandom_range(0, 7) * 8 +: 8];
        endcase
    endfunction

    // Input driver: present queued pixels, hold them until transfer, and apply
    // colour writes only once the output stream has drained.
    always @(posedge aclk) begin : drive_pixels
        logic nxt_valid;
        logic nxt_wr_en;
        logic holding;
        job_t head;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_wr_en <= 1'b0;
            colour_on = 1'b1;
            wait_left = -1;
        end else begin
            nxt_valid = s_valid;
            nxt_wr_en = 1'b0;
            holding   = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                predict_pixel_run(cur_pixel, colour_on);
                nxt_valid = 1'b0;
            end
            if (!holding && job_q.size() != 0) begin
                head = job_q[0];
                case (head.kind)
                    JOB_PIXEL: begin
                        if (wait_left < 0) begin
                            wait_left = head.gap;
                        end
                        if (wait_left == 0) begin
                            cur_pixel = head;
                            s_luminance <= head.lum;
                            s_red       <= head.red;
                            s_green     <= head.green;
                            s_blue      <= head.blue;
                            s_row_end   <= head.row_end;
                            nxt_valid = 1'b1;
                            wait_left = -1;
                            void'(job_q.pop_front());
                        end else begin
                            wait_left--;
                        end
                    end
                    JOB_SET_COLOUR: begin
                        if (stream_q.size() == 0) begin
                            nxt_wr_en = 1'b1;
                            cfg_wr_data <= head.colour;
                            colour_on = head.colour;
                            void'(job_q.pop_front());
                        end
                    end
                    default: begin
                        // hold off until every pending byte has come out
                        if (stream_q.size() == 0) begin
                            void'(job_q.pop_front());
                        end
                    end
                endcase
            end
            s_valid   <= nxt_valid;
            cfg_wr_en <= nxt_wr_en;
        end
    end

    // Output checker with random back-pressure.
    always @(posedge aclk) begin : check_stream
        term_byte_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            rx_mode    = 1;
            rx_count   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (stream_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, got byte %02h last %0b",
                             $time, m_out_byte, m_last);
                end else begin
                    want = stream_q.pop_front();
                    if (m_out_byte !== want.code) begin
                        mismatches++;
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.code, m_out_byte);
                    end
                    if (m_last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %0b, got %0b",
                                 $time, want.last, m_last);
                    end
                end
                rx_count++;
                if (rx_count % 64 == 0) begin
                    rx_mode = $urandom_range(0, 2);
                end
                case (rx_mode)
                    0:       stall_left = 0;
                    1:       stall_left = $urandom_range(0, MAX_GAP);
                    default: stall_left = ($urandom_range(0, 7) == 0) ?
                                          $urandom_range(0, MAX_GAP) : 0;
                endcase
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    initial begin : run_control
        job_t drain;
        int   i;
        int   p;
        int   k;
        int   gap;
        logic [7:0] lum;

        // thresholds either side, every glyph, all decimal widths
        for (i = 0; i < 19; i++) begin
            lum = (i == 0) ? 8'd0 : RAMP_BOUNDS[(8 - (i - 1) / 2) * 8 +: 8] - 8'(i % 2);
            add_pixel(lum, DEC_EDGES[(7 - i % 8) * 8 +: 8],
                      DEC_EDGES[(7 - (i + 3) % 8) * 8 +: 8],
                      DEC_EDGES[(7 - (i + 5) % 8) * 8 +: 8],
                      1'(i % 2), $urandom_range(0, MAX_GAP));
        end
        add_colour(1'b0);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0);
        add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        add_pixel(8'd140, 8'd7, 8'd77, 8'd177, 1'b1, $urandom_range(0, MAX_GAP));
        add_colour(1'b1);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            add_colour((p % 3) != 1);
            for (i = 0; i < PHASE_PIXELS; i++) begin
                case (p % 4)
                    0:       gap = 0;
                    2:       gap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_GAP) : 0;
                    default: gap = $urandom_range(0, MAX_GAP);
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    k   = $urandom_range(0, 8);
                    lum = RAMP_BOUNDS[(8 - k) * 8 +: 8] - 8'($urandom_range(0, 1));
                end else begin
                    lum = 8'($urandom_range(0, 255));
                end
                add_pixel(lum, random_component(), random_component(), random_component(),
                          ($urandom_range(0, 3) == 0), gap);
                if (p == 3 && i == PHASE_PIXELS / 2) begin
                    drain = job_q[job_q.size() - 1];
                    drain.kind = JOB_DRAIN;
                    job_q.push_back(drain);
                end
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (job_q.size() != 0 || s_valid || stream_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
